### hw/rtl/assert_macros.svh
// shared assertion macros for the rasterizer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds on every clock outside reset
`define BFR_ASSERT_ALWAYS(label, clk_sig, rst_sig, cond) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (cond)) \
        else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define BFR_ASSERT_IMPLY(label, clk_sig, rst_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

### hw/rtl/bfr_pkg.sv
package bfr_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_ORIGIN_X    = 2'd0;
    localparam logic [1:0] REG_ORIGIN_Y    = 2'd1;
    localparam logic [1:0] REG_GLYPH_SCALE = 2'd2;
    localparam logic [1:0] REG_FILL_COLOR  = 2'd3;

    localparam int GLYPH_ROWS = 5;
    localparam int GLYPH_COLS = 3;
    localparam int GLYPH_BITS = GLYPH_ROWS * GLYPH_COLS;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    // one character waiting for the pixel walker
    typedef struct packed {
        logic [GLYPH_BITS-1:0] bits;
        logic [15:0]           base_x;
        logic [3:0]            scale;
    } job_t;

    // rows given top first; row r sits at bits [3r+2:3r], leftmost column in the msb
    function automatic logic [GLYPH_BITS-1:0] rows5(
        input logic [2:0] r0,
        input logic [2:0] r1,
        input logic [2:0] r2,
        input logic [2:0] r3,
        input logic [2:0] r4
    );
        rows5 = {r4, r3, r2, r1, r0};
    endfunction

    // font rom, unknown codes draw as the blank glyph
    function automatic logic [GLYPH_BITS-1:0] glyph_bits(input logic [7:0] code);
        case (code)
            8'h30:   glyph_bits = rows5(3'd7, 3'd5, 3'd5, 3'd5, 3'd7); // 0
            8'h31:   glyph_bits = rows5(3'd2, 3'd6, 3'd2, 3'd2, 3'd7); // 1
            8'h32:   glyph_bits = rows5(3'd7, 3'd1, 3'd7, 3'd4, 3'd7); // 2
            8'h33:   glyph_bits = rows5(3'd7, 3'd1, 3'd7, 3'd1, 3'd7); // 3
            8'h34:   glyph_bits = rows5(3'd5, 3'd5, 3'd7, 3'd1, 3'd1); // 4
            8'h35:   glyph_bits = rows5(3'd7, 3'd4, 3'd7, 3'd1, 3'd7); // 5
            8'h36:   glyph_bits = rows5(3'd7, 3'd4, 3'd7, 3'd5, 3'd7); // 6
            8'h37:   glyph_bits = rows5(3'd7, 3'd1, 3'd1, 3'd1, 3'd1); // 7
            8'h38:   glyph_bits = rows5(3'd7, 3'd5, 3'd7, 3'd5, 3'd7); // 8
            8'h39:   glyph_bits = rows5(3'd7, 3'd5, 3'd7, 3'd1, 3'd7); // 9
            8'h46:   glyph_bits = rows5(3'd7, 3'd4, 3'd7, 3'd4, 3'd4); // F
            8'h50:   glyph_bits = rows5(3'd7, 3'd5, 3'd7, 3'd4, 3'd4); // P
            8'h53:   glyph_bits = rows5(3'd7, 3'd4, 3'd7, 3'd1, 3'd7); // S
            8'h2E:   glyph_bits = rows5(3'd0, 3'd0, 3'd0, 3'd0, 3'd1); // period
            default: glyph_bits = '0;
        endcase
    endfunction

endpackage

### hw/rtl/bfr_front.sv
module bfr_front #(
    parameter logic [15:0] COORD_MASK = 16'hFFFF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         char_code,
    input  logic               string_start,
    input  logic [11:0]        origin_x,
    input  logic [3:0]         glyph_scale,
    input  logic               q_full,
    output logic               q_push,
    output bfr_pkg::job_t      q_job
);

    logic [15:0]                     cursor_reg;
    logic [15:0]                     cursor_next;
    logic [15:0]                     cur_x;
    logic [3:0]                      eff_scale;
    logic [bfr_pkg::GLYPH_BITS-1:0]  bits;
    logic                            accept;

    assign full      = q_full;
    assign accept    = push && !q_full;
    assign eff_scale = (glyph_scale == 4'd0) ? 4'd1 : glyph_scale;
    assign cur_x     = string_start ? ({4'd0, origin_x} & COORD_MASK) : cursor_reg;
    assign bits      = bfr_pkg::glyph_bits(char_code);

    // blank glyphs only move the cursor
    assign q_push       = accept && (bits != '0);
    assign q_job.bits   = bits;
    assign q_job.base_x = cur_x;
    assign q_job.scale  = eff_scale;

    always_comb
    begin
        cursor_next = cursor_reg;
        if (accept)
        begin
            cursor_next = (cur_x + {10'd0, eff_scale, 2'b00}) & COORD_MASK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_reg <= '0;
        end
        else
        begin
            cursor_reg <= cursor_next;
        end
    end

endmodule

### hw/rtl/bfr_queue.sv
`include "assert_macros.svh"

module bfr_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  bfr_pkg::job_t      push_job,
    output logic               full,
    input  logic               pop,
    output logic               empty,
    output bfr_pkg::job_t      head_job
);

    bfr_pkg::job_t                mem_reg [bfr_pkg::QUEUE_DEPTH];
    logic [bfr_pkg::QPTR_W-1:0]   wr_ptr_reg;
    logic [bfr_pkg::QPTR_W-1:0]   wr_ptr_next;
    logic [bfr_pkg::QPTR_W-1:0]   rd_ptr_reg;
    logic [bfr_pkg::QPTR_W-1:0]   rd_ptr_next;
    logic [bfr_pkg::QCNT_W-1:0]   count_reg;
    logic [bfr_pkg::QCNT_W-1:0]   count_next;
    logic                         do_push;
    logic                         do_pop;

    assign full     = (count_reg == bfr_pkg::QCNT_W'(bfr_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_job = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    `BFR_ASSERT_ALWAYS(a_count_in_range, clk, rst_n, count_reg <= bfr_pkg::QCNT_W'(bfr_pkg::QUEUE_DEPTH))
    `BFR_ASSERT_IMPLY(a_no_push_when_full, clk, rst_n, push, !full)

endmodule

### hw/rtl/bfr_back.sv
`include "assert_macros.svh"

module bfr_back #(
    parameter logic [15:0] COORD_MASK = 16'hFFFF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  bfr_pkg::job_t      q_job,
    output logic               q_pop,
    input  logic [11:0]        origin_y,
    input  logic [31:0]        fill_color,
    output logic               empty,
    input  logic               pop,
    output logic [15:0]        rect_x,
    output logic [15:0]        rect_y,
    output logic [3:0]         rect_side,
    output logic [31:0]        rect_color,
    output logic               last_rect
);

    logic                            busy_reg;
    logic                            busy_next;
    logic [bfr_pkg::GLYPH_BITS-1:0]  bits_reg;
    logic [bfr_pkg::GLYPH_BITS-1:0]  bits_next;
    logic [15:0]                     base_reg;
    logic [3:0]                      scale_reg;
    logic                            out_valid_reg;
    logic                            out_valid_next;
    logic [15:0]                     rect_x_reg;
    logic [15:0]                     rect_y_reg;
    logic [3:0]                      rect_side_reg;
    logic [31:0]                     rect_color_reg;
    logic                            last_rect_reg;

    logic                            out_free;
    logic                            emit;
    logic                            load;
    logic [2:0]                      sel_r;
    logic [1:0]                      sel_c;
    logic [bfr_pkg::GLYPH_BITS-1:0]  sel_mask;
    logic [bfr_pkg::GLYPH_BITS-1:0]  remain;
    logic [5:0]                      x_off;
    logic [6:0]                      y_off;
    logic [15:0]                     pix_x;
    logic [15:0]                     pix_y;

    // first set pixel in scan order: rows top down, columns left to right
    always_comb
    begin
        sel_r    = '0;
        sel_c    = '0;
        sel_mask = '0;
        for (int r = bfr_pkg::GLYPH_ROWS - 1; r >= 0; r--)
        begin
            for (int c = bfr_pkg::GLYPH_COLS - 1; c >= 0; c--)
            begin
                if (bits_reg[r * bfr_pkg::GLYPH_COLS + (bfr_pkg::GLYPH_COLS - 1 - c)])
                begin
                    sel_r    = 3'(r);
                    sel_c    = 2'(c);
                    sel_mask = bfr_pkg::GLYPH_BITS'(1) <<
                               (r * bfr_pkg::GLYPH_COLS + (bfr_pkg::GLYPH_COLS - 1 - c));
                end
            end
        end
    end

    assign remain = bits_reg & ~sel_mask;

    always_comb
    begin
        case (sel_c)
            2'd1:    x_off = {2'd0, scale_reg};
            2'd2:    x_off = {1'b0, scale_reg, 1'b0};
            default: x_off = '0;
        endcase
    end

    assign y_off = 7'(sel_r) * 7'(scale_reg);
    assign pix_x = (base_reg + {10'd0, x_off}) & COORD_MASK;
    assign pix_y = ({4'd0, origin_y} + {9'd0, y_off}) & COORD_MASK;

    assign out_free = !out_valid_reg || pop;
    assign emit     = busy_reg && out_free;
    assign load     = !q_empty && (!busy_reg || (emit && (remain == '0)));
    assign q_pop    = load;

    always_comb
    begin
        busy_next      = busy_reg;
        bits_next      = bits_reg;
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b0;
        end
        if (emit)
        begin
            out_valid_next = 1'b1;
            bits_next      = remain;
            if (remain == '0)
            begin
                busy_next = 1'b0;
            end
        end
        if (load)
        begin
            busy_next = 1'b1;
            bits_next = q_job.bits;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg <= bits_next;
        if (load)
        begin
            base_reg  <= q_job.base_x;
            scale_reg <= q_job.scale;
        end
        if (emit)
        begin
            rect_x_reg     <= pix_x;
            rect_y_reg     <= pix_y;
            rect_side_reg  <= scale_reg;
            rect_color_reg <= fill_color;
            last_rect_reg  <= (remain == '0);
        end
    end

    assign empty      = !out_valid_reg;
    assign rect_x     = rect_x_reg;
    assign rect_y     = rect_y_reg;
    assign rect_side  = rect_side_reg;
    assign rect_color = rect_color_reg;
    assign last_rect  = last_rect_reg;

    `BFR_ASSERT_IMPLY(a_busy_has_pixels, clk, rst_n, busy_reg, bits_reg != '0)
    `BFR_ASSERT_IMPLY(a_side_nonzero, clk, rst_n, out_valid_reg, rect_side_reg != 4'd0)

endmodule

### hw/rtl/bitmap_font_text_rasterizer_top.sv
// channel    direction  handshake              payload
// input      in         push / full            char_code, string_start
// result     out        empty / pop            rect_x, rect_y, rect_side, rect_color, last_rect
// config     in         cfg_wr_en (no wait)    cfg_index, cfg_wdata
//
// the front looks up the glyph of each accepted character and advances the cursor
// the back emits one square per cycle unless the result is stalled, one per lit pixel (1 to 13)
// blank glyphs never reach the back and only move the cursor in the front
// a two entry request queue between front and back and the result register let each side stall
// rst_n clears the cursor, the queue, the back and the config registers to their defaults
module bitmap_font_text_rasterizer_top #(
    parameter int COORD_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    // input queue side
    input  logic         push,
    output logic         full,
    input  logic [7:0]   char_code,
    input  logic         string_start,
    // result queue side
    output logic         empty,
    input  logic         pop,
    output logic [15:0]  rect_x,
    output logic [15:0]  rect_y,
    output logic [3:0]   rect_side,
    output logic [31:0]  rect_color,
    output logic         last_rect,
    // configuration writes
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_wdata
);

    // coordinates wrap at COORD_BITS and are reported in 16 bits
    localparam logic [15:0] COORD_MASK =
        (COORD_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << COORD_BITS) - 32'd1);

    logic [11:0]     origin_x_reg;
    logic [11:0]     origin_y_reg;
    logic [3:0]      glyph_scale_reg;
    logic [31:0]     fill_color_reg;

    logic            q_push;
    logic            q_full;
    logic            q_pop;
    logic            q_empty;
    bfr_pkg::job_t   q_in_job;
    bfr_pkg::job_t   q_head_job;

    // configuration registers: write only while the block is idle; nothing enforces it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg    <= 12'd0;
            origin_y_reg    <= 12'd0;
            glyph_scale_reg <= 4'd1;
            fill_color_reg  <= 32'hFFFF_FFFF;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                bfr_pkg::REG_ORIGIN_X:    origin_x_reg    <= cfg_wdata[11:0];
                bfr_pkg::REG_ORIGIN_Y:    origin_y_reg    <= cfg_wdata[11:0];
                bfr_pkg::REG_GLYPH_SCALE: glyph_scale_reg <= cfg_wdata[3:0];
                bfr_pkg::REG_FILL_COLOR:  fill_color_reg  <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    // front: glyph lookup, cursor tracking, blank filtering
    bfr_front #(
        .COORD_MASK (COORD_MASK)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .char_code    (char_code),
        .string_start (string_start),
        .origin_x     (origin_x_reg),
        .glyph_scale  (glyph_scale_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_job        (q_in_job)
    );

    // request queue between the two halves
    bfr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (q_in_job),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head_job (q_head_job)
    );

    // back: pixel walker and result register
    bfr_back #(
        .COORD_MASK (COORD_MASK)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_job      (q_head_job),
        .q_pop      (q_pop),
        .origin_y   (origin_y_reg),
        .fill_color (fill_color_reg),
        .empty      (empty),
        .pop        (pop),
        .rect_x     (rect_x),
        .rect_y     (rect_y),
        .rect_side  (rect_side),
        .rect_color (rect_color),
        .last_rect  (last_rect)
    );

endmodule

### dv/rect_scoreboard_pkg.sv
`timescale 1ns / 1ps

package rect_scoreboard_pkg;

    // one filled square as it should leave the block
    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [3:0]  side;
        logic [31:0] color;
        logic        is_last;
    } rect_t;

    class rect_scoreboard;

        rect_t       expected_rects[$];
        logic [11:0] origin_x;
        logic [11:0] origin_y;
        logic [3:0]  scale;
        logic [31:0] color;
        logic [15:0] pen_x;
        int          errors;
        int          chars_seen;
        int          rects_checked;

        function new();
            origin_x      = '0;
            origin_y      = '0;
            scale         = 4'd1;
            color         = 32'hFFFF_FFFF;
            pen_x         = '0;
            errors        = 0;
            chars_seen    = 0;
            rects_checked = 0;
        endfunction

        function void write_reg(logic [1:0] index, logic [31:0] data);
            case (index)
                bfr_pkg::REG_ORIGIN_X:    origin_x = data[11:0];
                bfr_pkg::REG_ORIGIN_Y:    origin_y = data[11:0];
                bfr_pkg::REG_GLYPH_SCALE: scale    = data[3:0];
                bfr_pkg::REG_FILL_COLOR:  color    = data;
                default:                  ;
            endcase
        endfunction

        // 3x5 font, row 0 in bits [14:12], leftmost column in the msb of each row
        function logic [14:0] glyph(logic [7:0] code);
            case (code)
                8'h30:   glyph = {3'd7, 3'd5, 3'd5, 3'd5, 3'd7};
                8'h31:   glyph = {3'd2, 3'd6, 3'd2, 3'd2, 3'd7};
                8'h32:   glyph = {3'd7, 3'd1, 3'd7, 3'd4, 3'd7};
                8'h33:   glyph = {3'd7, 3'd1, 3'd7, 3'd1, 3'd7};
                8'h34:   glyph = {3'd5, 3'd5, 3'd7, 3'd1, 3'd1};
                8'h35:   glyph = {3'd7, 3'd4, 3'd7, 3'd1, 3'd7};
                8'h36:   glyph = {3'd7, 3'd4, 3'd7, 3'd5, 3'd7};
                8'h37:   glyph = {3'd7, 3'd1, 3'd1, 3'd1, 3'd1};
                8'h38:   glyph = {3'd7, 3'd5, 3'd7, 3'd5, 3'd7};
                8'h39:   glyph = {3'd7, 3'd5, 3'd7, 3'd1, 3'd7};
                8'h46:   glyph = {3'd7, 3'd4, 3'd7, 3'd4, 3'd4};
                8'h50:   glyph = {3'd7, 3'd5, 3'd7, 3'd4, 3'd4};
                8'h53:   glyph = {3'd7, 3'd4, 3'd7, 3'd1, 3'd7};
                8'h2E:   glyph = {3'd0, 3'd0, 3'd0, 3'd0, 3'd1};
                default: glyph = '0;
            endcase
        endfunction

        // expand one accepted character into the squares it draws
        function void note_char(logic [7:0] code, logic start);
            logic [14:0] bits;
            logic [3:0]  s;
            int          lit;
            int          n;
            rect_t       rect;
            s = (scale == 4'd0) ? 4'd1 : scale;
            if (start)
                pen_x = {4'd0, origin_x};
            bits = glyph(code);
            lit  = $countones(bits);
            n    = 0;
            for (int r = 0; r < 5; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    if (bits[14 - 3 * r - c])
                    begin
                        n++;
                        rect.x       = pen_x + 16'(c * s);
                        rect.y       = {4'd0, origin_y} + 16'(r * s);
                        rect.side    = s;
                        rect.color   = color;
                        rect.is_last = (n == lit);
                        expected_rects.push_back(rect);
                    end
                end
            end
            pen_x = pen_x + 16'(4 * s);
            chars_seen++;
        endfunction

        function void check_rect(logic [15:0] x, logic [15:0] y, logic [3:0] side,
                                 logic [31:0] fill, logic is_last);
            rect_t want;
            if (expected_rects.size() == 0)
            begin
                $error("square at x=%0d y=%0d with nothing expected", x, y);
                errors++;
                return;
            end
            want = expected_rects.pop_front();
            rects_checked++;
            if (x !== want.x)
            begin
                $error("rect_x mismatch: expected %0d, actual %0d", want.x, x);
                errors++;
            end
            if (y !== want.y)
            begin
                $error("rect_y mismatch: expected %0d, actual %0d", want.y, y);
                errors++;
            end
            if (side !== want.side)
            begin
                $error("rect_side mismatch: expected %0d, actual %0d", want.side, side);
                errors++;
            end
            if (fill !== want.color)
            begin
                $error("rect_color mismatch: expected %h, actual %h", want.color, fill);
                errors++;
            end
            if (is_last !== want.is_last)
            begin
                $error("last_rect mismatch: expected %0d, actual %0d", want.is_last, is_last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_rects.size();
        endfunction

    endclass

endpackage

### dv/tb_bitmap_font_text_rasterizer_top.sv
`timescale 1ns / 1ps

module tb_bitmap_font_text_rasterizer_top;

    // cycles with no accepted request on either side before the run is called hung
    localparam int STALL_LIMIT  = 2000;
    // pause after the last square so trailing blank characters leave the front
    localparam int SETTLE_CYCLES = 40;

    typedef struct packed {
        logic [7:0] code;
        logic       start;
    } char_req_t;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [7:0]  char_code;
    logic        string_start;
    logic        empty;
    logic        pop;
    logic [15:0] rect_x;
    logic [15:0] rect_y;
    logic [3:0]  rect_side;
    logic [31:0] rect_color;
    logic        last_rect;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_wdata;

    rect_scoreboard_pkg::rect_scoreboard sb;
    char_req_t      char_queue[$];
    int             idle_cycles;
    int             phases_run;
    int             cycle_count;

    // receiver stall pattern state
    int stall_mode;
    int mode_left;
    int hold_left;

    // glyphs that draw something, space excluded
    logic [7:0] drawn_codes[14] = '{8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
                                    8'h37, 8'h38, 8'h39, 8'h46, 8'h50, 8'h53, 8'h2E};

    bitmap_font_text_rasterizer_top #(
        .COORD_BITS(16)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .char_code    (char_code),
        .string_start (string_start),
        .empty        (empty),
        .pop          (pop),
        .rect_x       (rect_x),
        .rect_y       (rect_y),
        .rect_side    (rect_side),
        .rect_color   (rect_color),
        .last_rect    (last_rect),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata)
    );

    // 2 ns clock
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // monitor: both handshakes are judged on the values held just before the edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
                sb.note_char(char_code, string_start);
            if (pop && !empty)
                sb.check_rect(rect_x, rect_y, rect_side, rect_color, last_rect);
        end
    end

    // watchdog on stretches with no accepted request
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no request accepted for %0d cycles", STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // receiver: switches between free flow, coin flips, long stalls and a fixed cadence
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(30, 200);
        end
        mode_left--;
        case (stall_mode)
            0: pop <= 1'b1;
            1: pop <= 1'($urandom_range(0, 1));
            2:
            begin
                if (hold_left > 0)
                begin
                    hold_left--;
                    pop <= 1'b0;
                end
                else if ($urandom_range(0, 15) == 0)
                begin
                    hold_left = $urandom_range(5, 25);
                    pop <= 1'b0;
                end
                else
                begin
                    pop <= 1'b1;
                end
            end
            default: pop <= (cycle_count % 3 == 0);
        endcase
    end

    // one register write; the enable stays up so back-to-back writes need no gap
    task automatic write_reg(logic [1:0] index, logic [31:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= data;
        @(posedge clk);
        sb.write_reg(index, data);
    endtask

    // all four registers, only called while nothing is in flight
    task automatic load_config(logic [31:0] ox, logic [31:0] oy, logic [31:0] scale,
                               logic [31:0] fill);
        write_reg(bfr_pkg::REG_ORIGIN_X, ox);
        write_reg(bfr_pkg::REG_ORIGIN_Y, oy);
        write_reg(bfr_pkg::REG_GLYPH_SCALE, scale);
        write_reg(bfr_pkg::REG_FILL_COLOR, fill);
        cfg_wr_en <= 1'b0;
        phases_run++;
    endtask

    // sender: pushes the queued characters in bursts with random gaps between them
    task automatic drive_chars();
        char_req_t req;
        int        burst_left;
        int        gap;
        burst_left = $urandom_range(1, 16);
        while (char_queue.size() > 0)
        begin
            req = char_queue.pop_front();
            push         <= 1'b1;
            char_code    <= req.code;
            string_start <= req.start;
            @(posedge clk);
            while (full)
                @(posedge clk);
            burst_left--;
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 16);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0)
                begin
                    push <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
        push <= 1'b0;
    endtask

    // wait for every expected square, then let trailing blanks drain from the front
    // the first wait lets the monitor note the last accepted character
    task automatic settle();
        @(posedge clk);
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic add_char(logic [7:0] code, logic start);
        char_req_t req;
        req.code  = code;
        req.start = start;
        char_queue.push_back(req);
    endtask

    // mostly drawn glyphs, some spaces and some arbitrary codes
    function automatic logic [7:0] pick_code();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick <= 6)
            return drawn_codes[$urandom_range(0, 13)];
        else if (pick == 7)
            return 8'h20;
        else
            return 8'($urandom_range(0, 255));
    endfunction

    // strings: a start flag on the first character, now and then a string without one
    task automatic queue_random_strings(int count);
        int len;
        while (count > 0)
        begin
            len = $urandom_range(1, 8);
            for (int i = 0; i < len && count > 0; i++)
            begin
                if (i == 0)
                    add_char(pick_code(), $urandom_range(0, 7) != 0);
                else
                    add_char(pick_code(), $urandom_range(0, 19) == 0);
                count--;
            end
        end
    endtask

    // register data with random upper bits half the time
    function automatic logic [31:0] rand_coord();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0:       v = 32'd0;
            1:       v = 32'd4095;
            default: v = 32'($urandom_range(0, 4095));
        endcase
        if ($urandom_range(0, 1) == 1)
            v[31:12] = 20'($urandom());
        return v;
    endfunction

    function automatic logic [31:0] rand_scale();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0:       v = 32'd1;
            1:       v = 32'd15;
            2:       v = 32'd0;
            default: v = 32'($urandom_range(1, 15));
        endcase
        if ($urandom_range(0, 1) == 1)
            v[31:4] = 28'($urandom());
        return v;
    endfunction

    function automatic logic [31:0] rand_color();
        case ($urandom_range(0, 5))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    initial
    begin
        sb           = new();
        idle_cycles  = 0;
        phases_run   = 0;
        cycle_count  = 0;
        stall_mode   = 0;
        mode_left    = 0;
        hold_left    = 0;
        rst_n        = 1'b0;
        push         = 1'b0;
        char_code    = '0;
        string_start = 1'b0;
        pop          = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = bfr_pkg::REG_ORIGIN_X;
        cfg_wdata    = '0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: first character without a start flag draws from cursor 0
        add_char(8'h38, 1'b0);
        add_char(8'h30, 1'b1);
        add_char(8'h31, 1'b0);
        add_char(8'h32, 1'b0);
        add_char(8'h33, 1'b0);
        add_char(8'h34, 1'b0);
        add_char(8'h35, 1'b1);
        add_char(8'h36, 1'b0);
        add_char(8'h37, 1'b0);
        add_char(8'h39, 1'b0);
        add_char(8'h46, 1'b0);
        add_char(8'h50, 1'b1);
        add_char(8'h53, 1'b0);
        add_char(8'h2E, 1'b0);
        // blank glyphs: space and unknown codes draw nothing but move the cursor; drawn ones mixed in
        add_char(8'h20, 1'b0);
        add_char(8'h00, 1'b0);
        add_char(8'h31, 1'b0);
        add_char(8'hFF, 1'b1);
        add_char(8'h41, 1'b0);
        add_char(8'h7F, 1'b0);
        add_char(8'h2E, 1'b0);
        drive_chars();
        settle();

        // largest origin and scale, black fill
        load_config(32'd4095, 32'd4095, 32'd15, 32'h0000_0000);
        add_char(8'h38, 1'b1);
        add_char(8'h2E, 1'b0);
        add_char(8'h20, 1'b0);
        add_char(8'h31, 1'b0);
        drive_chars();
        settle();

        // scale zero behaves as scale one
        load_config(32'd0, 32'd0, 32'd0, 32'hA5A5_5A5A);
        add_char(8'h30, 1'b1);
        add_char(8'h34, 1'b0);
        add_char(8'h80, 1'b0);
        add_char(8'h2E, 1'b0);
        drive_chars();
        settle();

        // random phases, each with its own register settings
        for (int p = 0; p < 8; p++)
        begin
            load_config(rand_coord(), rand_coord(), rand_scale(), rand_color());
            queue_random_strings(45);
            drive_chars();
            settle();
        end

        $display("covered %0d characters over %0d register settings, %0d squares checked",
                 sb.chars_seen, phases_run + 1, sb.rects_checked);
        $display("including blank glyphs, scale zero and origin extremes");
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
